// File: src/usan_pkg.sv
// Shared types and constants for the UTF-8 sanitizer.
`timescale 1ns / 1ps
`default_nettype none

package usan_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  localparam logic [20:0] CP_MAX  = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] MIN_2   = 21'h000080;
  localparam logic [20:0] MIN_3   = 21'h000800;
  localparam logic [20:0] MIN_4   = 21'h010000;

  // What the back end does at one byte position of a command.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PASS,
    OP_REPL
  } op_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       out_text_end;
  } out_word_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    op_t  [3:0]      ops;
    logic            text_end;
  } cmd_t;

endpackage

`default_nettype wire

// File: src/usan_front.sv
// Front end: holds pending bytes, classifies each byte position and builds commands.
`timescale 1ns / 1ps
`default_nettype none

module usan_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  usan_pkg::in_word_t data,
  output logic              cmd_push,
  output usan_pkg::cmd_t    cmd,
  output logic [1:0]        pend_count
);
  import usan_pkg::*;

  typedef enum logic [1:0] {
    ST_PASS,
    ST_FAIL,
    ST_WAIT
  } seq_kind_t;

  typedef struct packed {
    seq_kind_t  kind;
    logic [2:0] len;
  } seq_res_t;

  logic [2:0][7:0] pending_bytes;
  logic [2:0][7:0] pending_bytes_next;
  logic [1:0]      pending_count;
  logic [2:0]      pend_n;
  logic [2:0]      n;
  logic [3:0][7:0] buf_b;
  seq_res_t        res [4];
  op_t  [3:0]      ops;
  logic [2:0]      p;
  logic            stopped;
  logic [2:0]      idx;

  // Judges the sequence that starts at b[0] given the bytes available so far.
  function automatic seq_res_t check_seq(input logic [3:0][7:0] b, input logic [2:0] avail,
                                         input logic last);
    logic [2:0]  len;
    logic [20:0] minv;
    logic [20:0] cp;
    logic [2:0]  span;
    logic        cont_ok;
    seq_res_t    r;
    len  = 3'd0;
    minv = '0;
    cp   = '0;
    r.kind = ST_FAIL;
    r.len  = 3'd1;
    if (!b[0][7]) len = 3'd1;
    else if (b[0][7:5] == 3'b110) begin
      len = 3'd2;
      minv = MIN_2;
    end else if (b[0][7:4] == 4'b1110) begin
      len = 3'd3;
      minv = MIN_3;
    end else if (b[0][7:3] == 5'b11110) begin
      len = 3'd4;
      minv = MIN_4;
    end
    span = (avail < len) ? avail : len;
    cont_ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < span && b[i][7:6] != 2'b10) cont_ok = 1'b0;
    end
    case (len)
      3'd2:    cp = 21'({b[0][4:0], b[1][5:0]});
      3'd3:    cp = 21'({b[0][3:0], b[1][5:0], b[2][5:0]});
      3'd4:    cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      default: cp = '0;
    endcase
    if (len == 3'd1) begin
      r.kind = ST_PASS;
    end else if (len == 3'd0 || !cont_ok) begin
      r.kind = ST_FAIL;
    end else if (avail < len) begin
      r.kind = last ? ST_FAIL : ST_WAIT;
    end else if (cp < minv || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
      r.kind = ST_FAIL;
    end else begin
      r.kind = ST_PASS;
      r.len  = len;
    end
    return r;
  endfunction

  assign n = {1'b0, pending_count} + 3'd1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < {1'b0, pending_count}) buf_b[i] = pending_bytes[i];
      else if (3'(i) == {1'b0, pending_count}) buf_b[i] = data.in_byte;
      else buf_b[i] = 8'h00;
    end
  end

  // Every start position is judged in parallel; the walk below picks the ones reached.
  always_comb begin
    logic [3:0][7:0] sb;
    for (int s = 0; s < 4; s++) begin
      for (int i = 0; i < 4; i++) begin
        sb[i] = (s + i < 4) ? buf_b[(s + i) % 4] : 8'h00;
      end
      res[s] = check_seq(sb, n - 3'(s), data.text_end);
    end
  end

  always_comb begin
    p       = 3'd0;
    stopped = 1'b0;
    ops     = '{default: OP_NONE};
    for (int step = 0; step < 4; step++) begin
      if (!stopped && p < n) begin
        case (res[p[1:0]].kind)
          ST_PASS: begin
            for (int j = 0; j < 4; j++) begin
              if (3'(j) >= p && 3'(j) < p + res[p[1:0]].len) ops[j] = OP_PASS;
            end
            p = p + res[p[1:0]].len;
          end
          ST_FAIL: begin
            ops[p[1:0]] = OP_REPL;
            p = p + 3'd1;
          end
          default: stopped = 1'b1;
        endcase
      end
    end
    pend_n = n - p;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      idx = p + 3'(j);
      pending_bytes_next[j] = (idx < 3'd4) ? buf_b[idx[1:0]] : pending_bytes[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
    end else if (accept) begin
      pending_count <= pend_n[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_bytes <= pending_bytes_next;
    end
  end

  assign cmd_push     = accept && (ops[0] != OP_NONE);
  assign cmd.bytes    = buf_b;
  assign cmd.ops      = ops;
  assign cmd.text_end = data.text_end;
  assign pend_count   = pending_count;

endmodule

`default_nettype wire

// File: src/usan_queue.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module usan_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  usan_pkg::cmd_t wr_data,
  output logic           q_full,
  input  logic           rd_en,
  output logic           head_valid,
  output usan_pkg::cmd_t head
);
  import usan_pkg::*;

  cmd_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      if (wr_en && !rd_en) count <= count + 1'b1;
      else if (rd_en && !wr_en) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign q_full     = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// File: src/usan_back.sv
// Back end: walks one command a byte at a time into the output register.
`timescale 1ns / 1ps
`default_nettype none

module usan_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  usan_pkg::cmd_t      head,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output usan_pkg::out_word_t result
);
  import usan_pkg::*;

  logic       out_valid;
  out_word_t  out_reg;
  logic [1:0] pos;
  logic [1:0] sub;
  op_t        cur_op;
  logic [7:0] cur_byte;
  logic       token_done;
  logic       later_any;
  logic       last;
  logic       advance;

  assign cur_op = head.ops[pos];

  always_comb begin
    case (cur_op)
      OP_PASS: cur_byte = head.bytes[pos];
      OP_REPL: begin
        case (sub)
          2'd0:    cur_byte = REPL_B0;
          2'd1:    cur_byte = REPL_B1;
          default: cur_byte = REPL_B2;
        endcase
      end
      default: cur_byte = 8'h00;
    endcase
  end

  // Positions in a command are used from the first one on without gaps.
  assign token_done = (cur_op != OP_REPL) || (sub == 2'd2);
  assign later_any  = (pos != 2'd3) && (head.ops[pos + 2'd1] != OP_NONE);
  assign last       = token_done && !later_any;
  assign advance    = head_valid && (!out_valid || pop);
  assign q_pop      = advance && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 2'd0;
      sub       <= 2'd0;
    end else begin
      if (advance) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (advance) begin
        if (last) begin
          pos <= 2'd0;
          sub <= 2'd0;
        end else if (token_done) begin
          pos <= pos + 2'd1;
          sub <= 2'd0;
        end else begin
          sub <= sub + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg.out_byte     <= cur_byte;
      out_reg.run_last     <= last;
      out_reg.out_text_end <= head.text_end;
    end
  end

  assign empty  = !out_valid;
  assign result = out_reg;

endmodule

`default_nettype wire

// File: src/utf8_sanitizer_unit.sv
// The result words of an accepted byte pass through the command queue and then the output register.
// Throughput: one input byte per cycle; the output drains one byte per cycle while popped, so a
// replacement (three bytes) or a flushed tail holds the input back once the four-entry
// command queue fills. Bytes of an unfinished sequence wait in the front end.
// Reset (synchronous, active high) empties the pending store, the queue and the output word.
`timescale 1ns / 1ps
`default_nettype none

module utf8_sanitizer_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  usan_pkg::in_word_t  data,
  output logic                empty,
  input  logic                pop,
  output usan_pkg::out_word_t result
);
  import usan_pkg::*;

  logic       accept;
  logic       cmd_push;
  cmd_t       cmd;
  logic [1:0] pend_count;
  logic       q_full;
  logic       q_pop;
  logic       head_valid;
  cmd_t       head;

  assign full   = q_full;
  assign accept = push && !q_full;

  usan_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data       (data),
    .cmd_push   (cmd_push),
    .cmd        (cmd),
    .pend_count (pend_count)
  );

  usan_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (cmd_push),
    .wr_data    (cmd),
    .q_full     (q_full),
    .rd_en      (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  usan_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  // The queue is never written while it is full.
  assert property (@(posedge clk) disable iff (rst) cmd_push |-> !q_full)
    else $error("command queue written while full");

  // The last byte of a text leaves nothing pending.
  assert property (@(posedge clk) disable iff (rst)
                   (accept && data.text_end) |=> (pend_count == 2'd0))
    else $error("bytes still pending after end of text");

  // A plain ASCII byte always yields a command.
  assert property (@(posedge clk) disable iff (rst)
                   (accept && !data.in_byte[7]) |-> cmd_push)
    else $error("ASCII byte produced no command");

endmodule

`default_nettype wire

// File: verif/tb_utf8_sanitizer_unit.sv
// Self-checking testbench for the UTF-8 sanitizer with a byte-level repair predictor.
`timescale 1ns / 1ps

module tb_utf8_sanitizer_unit;
  import usan_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 120;
  localparam int RANDOM_LEN  = 420;

  // Predicts the repaired stream. Only the held bytes are kept, since the announced
  // length and the partial code point follow from them.
  class utf8_scoreboard;
    out_word_t   repair_q[$];
    logic [7:0]  held[3];
    int unsigned held_cnt = 0;
    int unsigned errors = 0;

    function void emit(logic [7:0] b, logic te);
      out_word_t w;
      w.out_byte     = b;
      w.run_last     = 1'b0;
      w.out_text_end = te;
      repair_q = {repair_q, w};
    endfunction

    function void note_byte(in_word_t w);
      logic [7:0]  seq[4];
      logic [20:0] cp;
      logic [20:0] floor_cp;
      out_word_t   tail;
      int          n;
      int          i;
      int          need;
      int          consume;
      int          first;
      bit          bad;
      bit          hold;
      first = repair_q.size();
      n = 0;
      for (i = 0; i < held_cnt; i++) begin
        seq[n] = held[i];
        n++;
      end
      seq[n] = w.in_byte;
      n++;
      while (n > 0) begin
        consume  = 1;
        bad      = 1'b0;
        hold     = 1'b0;
        cp       = '0;
        floor_cp = '0;
        casez (seq[0])
          8'b0???????: need = 1;
          8'b110?????: begin
            need = 2;
            floor_cp = MIN_2;
            cp = {16'd0, seq[0][4:0]};
          end
          8'b1110????: begin
            need = 3;
            floor_cp = MIN_3;
            cp = {17'd0, seq[0][3:0]};
          end
          8'b11110???: begin
            need = 4;
            floor_cp = MIN_4;
            cp = {18'd0, seq[0][2:0]};
          end
          default: need = 0;
        endcase
        if (need == 1) begin
          emit(seq[0], w.text_end);
        end else if (need == 0) begin
          bad = 1'b1;
        end else begin
          for (i = 1; i < n && i < need; i++) begin
            if (seq[i][7:6] != 2'b10) begin
              bad = 1'b1;
              break;
            end
            cp = {cp[14:0], seq[i][5:0]};
          end
          if (!bad && n < need) begin
            if (w.text_end) bad = 1'b1;
            else hold = 1'b1;
          end else if (!bad) begin
            if (cp < floor_cp || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
              bad = 1'b1;
            end else begin
              for (i = 0; i < need; i++) emit(seq[i], w.text_end);
              consume = need;
            end
          end
        end
        if (hold) break;
        if (bad) begin
          emit(REPL_B0, w.text_end);
          emit(REPL_B1, w.text_end);
          emit(REPL_B2, w.text_end);
        end
        for (i = 0; i + consume < n; i++) seq[i] = seq[i + consume];
        n -= consume;
      end
      held_cnt = n;
      for (i = 0; i < n; i++) held[i] = seq[i];
      if (repair_q.size() > first) begin
        tail = repair_q[repair_q.size() - 1];
        tail.run_last = 1'b1;
        repair_q[repair_q.size() - 1] = tail;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (repair_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: byte %02h last %0b end %0b",
                   got.out_byte, got.run_last, got.out_text_end);
      end else begin
        want = repair_q.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.out_text_end !== want.out_text_end) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %02h last %0b end %0b, got byte %02h last %0b end %0b",
                     want.out_byte, want.run_last, want.out_text_end,
                     got.out_byte, got.run_last, got.out_text_end);
        end
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      full;
  in_word_t  data = '0;
  logic      empty;
  logic      pop = 1'b0;
  out_word_t result;

  utf8_scoreboard sb = new();
  in_word_t       text_q[$];
  int             directed_n;
  int             midway;
  int             cycles = 0;
  int             words_taken = 0;

  utf8_sanitizer_unit dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .data   (data),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else if (!rst) begin
      if (push && !full) sb.note_byte(data);
      if (pop && !empty) begin
        sb.check_word(result);
        words_taken++;
      end
    end
  end

  task automatic put_raw(input logic [7:0] b, input bit te);
    in_word_t w;
    w.in_byte  = b;
    w.text_end = te;
    text_q = {text_q, w};
  endtask

  // One random piece of text: mostly well-formed characters, the rest broken forms.
  task automatic add_random_piece();
    logic [7:0]  enc[4];
    logic [20:0] cp;
    int          pick;
    int          len;
    int          keep;
    int          i;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(1, 4);
    if (pick < 70) begin
      case (len)
        1: cp = 21'($urandom_range(0, 'h7F));
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h002000;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
    end else if (pick < 76) begin
      len = $urandom_range(2, 4);
      cp  = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
    end else if (pick < 80) begin
      len = 3;
      cp  = 21'($urandom_range('hD800, 'hDFFF));
    end else if (pick < 84) begin
      len = 4;
      cp  = 21'($urandom_range('h110000, 'h1FFFFF));
    end else if (pick < 92) begin
      len = $urandom_range(2, 4);
      cp  = 21'((len == 2) ? $urandom_range('h80, 'h7FF) :
                (len == 3) ? $urandom_range('h800, 'hD7FF) :
                $urandom_range('h10000, 'h10FFFF));
    end else begin
      len = 1;
      cp  = '0;
    end
    case (len)
      1: enc[0] = (pick >= 92) ? 8'($urandom_range(0, 255)) : {1'b0, cp[6:0]};
      2: begin
        enc[0] = {3'b110, cp[10:6]};
        enc[1] = {2'b10, cp[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, cp[15:12]};
        enc[1] = {2'b10, cp[11:6]};
        enc[2] = {2'b10, cp[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, cp[20:18]};
        enc[1] = {2'b10, cp[17:12]};
        enc[2] = {2'b10, cp[11:6]};
        enc[3] = {2'b10, cp[5:0]};
      end
    endcase
    keep = (pick >= 84 && pick < 92) ? $urandom_range(1, len - 1) : len;
    for (i = 0; i < keep; i++) put_raw(enc[i], $urandom_range(0, 39) == 0);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    push = 1'b0;
    while (sb.repair_q.size() != 0) @(negedge clk);
  endtask

  task automatic send_text();
    int i;
    int burst;
    int gap;
    i = 0;
    while (i < text_q.size()) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && i < text_q.size()) begin
        if (i == directed_n || i == midway) wait_drained();
        @(negedge clk);
        push = 1'b1;
        data = text_q[i];
        do @(posedge clk); while (full);
        i++;
        burst--;
      end
      gap = ($urandom_range(0, 1) == 0) ? 0 :
            ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      if (gap > 0) begin
        @(negedge clk);
        push = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    push = 1'b0;
  endtask

  // The receiver switches between stall patterns and once holds off long enough
  // for the block to fill up and push back on the sender.
  initial begin : receiver
    int  mode;
    int  span;
    int  hold_left;
    bit  long_done;
    span      = 0;
    mode      = 0;
    hold_left = 0;
    long_done = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!long_done && words_taken >= 120) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(20, 100);
        end
        span--;
        case (mode)
          0:       pop = 1'b1;
          1:       pop = $urandom_range(0, 1);
          default: pop = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    // Directed text: ASCII extremes, a good two-byte form, an overlong form, a surrogate,
    // a point above the Unicode range, a good four-byte form, a sequence cut short by an
    // ASCII byte, a bad lead, a stray continuation and a text that ends mid-sequence.
    put_raw(8'h00, 0); put_raw(8'h7F, 0);
    put_raw(8'hC2, 0); put_raw(8'h80, 0);
    put_raw(8'hC0, 0); put_raw(8'hAF, 0);
    put_raw(8'hED, 0); put_raw(8'hA0, 0); put_raw(8'h80, 0);
    put_raw(8'hF4, 0); put_raw(8'h90, 0); put_raw(8'h80, 0); put_raw(8'h80, 0);
    put_raw(8'hF0, 0); put_raw(8'h9F, 0); put_raw(8'h98, 0); put_raw(8'h80, 0);
    put_raw(8'hE2, 0); put_raw(8'h82, 0); put_raw(8'h41, 0);
    put_raw(8'hFF, 0);
    put_raw(8'h80, 0);
    put_raw(8'hF0, 0); put_raw(8'h90, 0); put_raw(8'h80, 1);
    directed_n = text_q.size();
    midway     = directed_n + RANDOM_LEN / 2;
    while (text_q.size() < directed_n + RANDOM_LEN) add_random_piece();
    // Close the text so that any held bytes get flushed.
    text_q[text_q.size() - 1].text_end = 1'b1;

    repeat (9) @(negedge clk);
    rst = 1'b0;
    send_text();
    while (sb.repair_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (sb.errors == 0 && sb.repair_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
